// ----- src/assert_macros.svh -----
// assertion helpers for the encoder and button qualifier
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the block clock, held off during reset
`define EBIQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on the following edge
`define EBIQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- src/ebiq_pkg.sv -----
package ebiq_pkg;

  localparam int unsigned CountW     = 16;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned ThreshW    = 15;
  localparam int unsigned MsW        = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [CountW-1:0]  CountReset     = 16'd32000;
  localparam logic [ThreshW-1:0] StepThreshRst  = 15'd4;
  localparam logic [MsW-1:0]     LongPressRst   = 16'd600;
  localparam logic [MsW-1:0]     DebounceRst    = 16'd100;

  localparam logic signed [1:0]  StepNone = 2'sd0;
  localparam logic signed [1:0]  StepPos  = 2'sd1;
  localparam logic signed [1:0]  StepNeg  = -2'sd1;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_AUX   = 2'd2,
    EV_LONG  = 2'd3
  } button_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_THRESHOLD = 2'd0,
    REG_HOLD_LIMIT     = 2'd1,
    REG_DEBOUNCE_MS    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ThreshW-1:0] step_threshold;
    logic [MsW-1:0]     hold_limit_ms;
    logic [MsW-1:0]     debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] encoder_count;
    logic              main_pressed;
    logic              aux_pressed;
    logic [TimeW-1:0]  now_ms;
  } sample_t;

  typedef struct packed {
    logic signed [1:0] enc_step;
    button_event_e     button_event;
    logic              clear_alarm;
  } result_t;

endpackage

// ----- src/ebiq_if.sv -----
interface ebiq_in_if;
  logic                           valid;
  logic                           ready;
  logic [ebiq_pkg::CountW-1:0]    encoder_count;
  logic                           main_pressed;
  logic                           aux_pressed;
  logic [ebiq_pkg::TimeW-1:0]     now_ms;

  modport source (output valid, encoder_count, main_pressed, aux_pressed, now_ms,
                  input ready);
  modport sink (input valid, encoder_count, main_pressed, aux_pressed, now_ms,
                output ready);
endinterface

interface ebiq_out_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] enc_step;
  logic [1:0]        button_event;
  logic              clear_alarm;

  modport source (output valid, enc_step, button_event, clear_alarm, input ready);
  modport sink (input valid, enc_step, button_event, clear_alarm, output ready);
endinterface

interface ebiq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ebiq_pkg::CfgIdxW-1:0]    index;
  logic [ebiq_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/ebiq_core.sv -----
module ebiq_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ebiq_pkg::cfg_t    cfg_i,
  input  ebiq_pkg::sample_t sample_i,
  input  logic              advance_i,
  output ebiq_pkg::result_t result_o
);

  logic [ebiq_pkg::CountW-1:0] last_count_q, last_count_d;
  logic                        press_active_q, press_active_d;
  logic [ebiq_pkg::TimeW-1:0]  press_start_q, press_start_d;
  logic                        long_done_q, long_done_d;
  logic [ebiq_pkg::TimeW-1:0]  last_aux_q, last_aux_d;

  logic [ebiq_pkg::CountW-1:0] delta;
  logic [ebiq_pkg::CountW-1:0] mag;
  logic                        negative;
  logic                        take_step;
  logic [ebiq_pkg::TimeW-1:0]  held_ms;
  logic [ebiq_pkg::TimeW-1:0]  aux_gap_ms;
  logic                        past_long;
  logic                        past_debounce;
  logic                        aux_fire;
  ebiq_pkg::button_event_e     event_d;

  // signed 16-bit change, magnitude reaches 32768 on the most negative value
  assign delta     = sample_i.encoder_count - last_count_q;
  assign negative  = delta[ebiq_pkg::CountW-1];
  assign mag       = negative ? (~delta + 16'd1) : delta;
  assign take_step = mag >= {1'b0, cfg_i.step_threshold};

  assign held_ms       = sample_i.now_ms - press_start_q;
  assign aux_gap_ms    = sample_i.now_ms - last_aux_q;
  assign past_long     = held_ms > {16'd0, cfg_i.hold_limit_ms};
  assign past_debounce = held_ms > {16'd0, cfg_i.debounce_ms};
  assign aux_fire      = sample_i.aux_pressed && (aux_gap_ms > {16'd0, cfg_i.debounce_ms});

  always_comb begin
    last_count_d   = take_step ? sample_i.encoder_count : last_count_q;
    press_active_d = press_active_q;
    press_start_d  = press_start_q;
    long_done_d    = long_done_q;
    last_aux_d     = last_aux_q;
    event_d        = ebiq_pkg::EV_NONE;

    if (sample_i.main_pressed) begin
      if (!press_active_q) begin
        // first held sample only opens the press
        press_active_d = 1'b1;
        press_start_d  = sample_i.now_ms;
        long_done_d    = 1'b0;
      end else if (!long_done_q && past_long) begin
        event_d     = ebiq_pkg::EV_LONG;
        long_done_d = 1'b1;
      end
    end else if (press_active_q) begin
      if (!long_done_q && past_debounce) begin
        event_d = ebiq_pkg::EV_SHORT;
      end
      press_active_d = 1'b0;
      long_done_d    = 1'b0;
    end

    // aux wins over any main button event, main state still moves on
    if (aux_fire) begin
      event_d    = ebiq_pkg::EV_AUX;
      last_aux_d = sample_i.now_ms;
    end

    result_o.button_event = event_d;
    result_o.clear_alarm  = aux_fire;
    if (!take_step) begin
      result_o.enc_step = ebiq_pkg::StepNone;
    end else if (!negative && (delta != '0)) begin
      result_o.enc_step = ebiq_pkg::StepNeg;
    end else begin
      result_o.enc_step = ebiq_pkg::StepPos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q   <= ebiq_pkg::CountReset;
      press_active_q <= 1'b0;
      press_start_q  <= '0;
      long_done_q    <= 1'b0;
      last_aux_q     <= '0;
    end else if (advance_i) begin
      last_count_q   <= last_count_d;
      press_active_q <= press_active_d;
      press_start_q  <= press_start_d;
      long_done_q    <= long_done_d;
      last_aux_q     <= last_aux_d;
    end
  end

endmodule

// ----- src/encoder_button_input_qualifier_top.sv -----
// encoder detent and button press qualifier
// path: sample register, then result register, both held while the output stalls
// throughput: one sample per cycle while the output is not stalled, the only loop is the state update
// between the sample register and the result register
// reset: asynchronous active low, restores config defaults, clears valid flags and core state, not the data registers
`include "assert_macros.svh"

module encoder_button_input_qualifier_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  ebiq_in_if.sink    in_i,
  ebiq_out_if.source out_o,
  ebiq_cfg_if.sink   cfg_i
);

  ebiq_pkg::cfg_t    cfg_q;
  logic              s1_valid_q;
  ebiq_pkg::sample_t s1_sample_q;
  logic              out_valid_q;
  ebiq_pkg::result_t out_res_q;
  ebiq_pkg::result_t core_res;
  logic              s1_move;
  logic              in_take;

  assign s1_move = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_take = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_threshold <= ebiq_pkg::StepThreshRst;
      cfg_q.hold_limit_ms  <= ebiq_pkg::LongPressRst;
      cfg_q.debounce_ms    <= ebiq_pkg::DebounceRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ebiq_pkg::REG_STEP_THRESHOLD: cfg_q.step_threshold <= cfg_i.data[ebiq_pkg::ThreshW-1:0];
        ebiq_pkg::REG_HOLD_LIMIT:     cfg_q.hold_limit_ms  <= cfg_i.data;
        ebiq_pkg::REG_DEBOUNCE_MS:    cfg_q.debounce_ms    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_sample_q.encoder_count <= in_i.encoder_count;
      s1_sample_q.main_pressed  <= in_i.main_pressed;
      s1_sample_q.aux_pressed   <= in_i.aux_pressed;
      s1_sample_q.now_ms        <= in_i.now_ms;
    end
  end

  ebiq_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .sample_i  (s1_sample_q),
    .advance_i (s1_move),
    .result_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.enc_step     = out_res_q.enc_step;
  assign out_o.button_event = out_res_q.button_event;
  assign out_o.clear_alarm  = out_res_q.clear_alarm;

  // alarm clear travels only with an aux press beat
  `EBIQ_ASSERT(a_clear_with_aux,
    !out_valid_q || (out_res_q.clear_alarm == (out_res_q.button_event == ebiq_pkg::EV_AUX)),
    "clear_alarm out of step with aux press")
  // the unused step code never reaches the result register
  `EBIQ_ASSERT(a_step_code, !out_valid_q || (out_res_q.enc_step != 2'sb10),
    "illegal detent step code")
  // a held sample is not dropped while the result side stalls
  `EBIQ_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_move, s1_valid_q && $stable(s1_sample_q),
    "sample register lost a stalled beat")
  // sample register never blocks intake while it is empty
  `EBIQ_ASSERT(a_ready_when_empty, s1_valid_q || in_i.ready, "intake blocked with empty stage")

endmodule

// ----- tb/ebiq_checker.sv -----
`timescale 1ns / 100ps

module qualifier_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ebiq_in_if          smp_i,
  ebiq_out_if         res_i,
  ebiq_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // configuration copy
  logic [ebiq_pkg::ThreshW-1:0] thresh;
  logic [ebiq_pkg::MsW-1:0]     long_ms;
  logic [ebiq_pkg::MsW-1:0]     deb_ms;

  // qualifier state
  logic [ebiq_pkg::CountW-1:0]  ref_count;
  logic                         held;
  logic [ebiq_pkg::TimeW-1:0]   hold_start;
  logic                         long_fired;
  logic [ebiq_pkg::TimeW-1:0]   aux_stamp;

  ebiq_pkg::result_t            step_event_q[$];
  ebiq_pkg::result_t            want;
  ebiq_pkg::sample_t            smp;

  function automatic ebiq_pkg::result_t qualify_sample(ebiq_pkg::sample_t s);
    ebiq_pkg::result_t           r;
    logic [ebiq_pkg::CountW-1:0] delta;
    logic [ebiq_pkg::CountW:0]   mag;
    logic                        neg;
    logic [ebiq_pkg::TimeW-1:0]  held_for;
    r.enc_step     = ebiq_pkg::StepNone;
    r.button_event = ebiq_pkg::EV_NONE;
    r.clear_alarm  = 1'b0;

    // change read as two's complement, -32768 keeps magnitude 32768
    delta = s.encoder_count - ref_count;
    neg   = delta[ebiq_pkg::CountW-1];
    mag   = neg ? (17'h10000 - {1'b0, delta}) : {1'b0, delta};
    if (mag >= {2'b00, thresh}) begin
      r.enc_step = (!neg && delta != '0) ? ebiq_pkg::StepNeg : ebiq_pkg::StepPos;
      ref_count  = s.encoder_count;
    end

    held_for = s.now_ms - hold_start;
    if (s.main_pressed) begin
      if (!held) begin
        held       = 1'b1;
        hold_start = s.now_ms;
        long_fired = 1'b0;
      end else if (!long_fired && held_for > {16'h0000, long_ms}) begin
        r.button_event = ebiq_pkg::EV_LONG;
        long_fired     = 1'b1;
      end
    end else if (held) begin
      if (!long_fired && held_for > {16'h0000, deb_ms}) begin
        r.button_event = ebiq_pkg::EV_SHORT;
      end
      held       = 1'b0;
      long_fired = 1'b0;
    end

    // aux press wins over any main-button event
    if (s.aux_pressed && (s.now_ms - aux_stamp) > {16'h0000, deb_ms}) begin
      r.button_event = ebiq_pkg::EV_AUX;
      r.clear_alarm  = 1'b1;
      aux_stamp      = s.now_ms;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_v);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, exp_v);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh       = ebiq_pkg::StepThreshRst;
      long_ms      = ebiq_pkg::LongPressRst;
      deb_ms       = ebiq_pkg::DebounceRst;
      ref_count    = ebiq_pkg::CountReset;
      held         = 1'b0;
      hold_start   = '0;
      long_fired   = 1'b0;
      aux_stamp    = '0;
      step_event_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          ebiq_pkg::REG_STEP_THRESHOLD: thresh  = cfg_i.data[ebiq_pkg::ThreshW-1:0];
          ebiq_pkg::REG_HOLD_LIMIT:     long_ms = cfg_i.data;
          ebiq_pkg::REG_DEBOUNCE_MS:    deb_ms  = cfg_i.data;
          default: ;
        endcase
      end
      if (res_i.valid && res_i.ready) begin
        if (step_event_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", int'(res_i.button_event), -1);
        end else begin
          want = step_event_q.pop_front();
          if (res_i.enc_step !== want.enc_step)
            report_mismatch("enc_step", int'(res_i.enc_step), int'(want.enc_step));
          if (res_i.button_event !== want.button_event)
            report_mismatch("button_event", int'(res_i.button_event),
                            int'(want.button_event));
          if (res_i.clear_alarm !== want.clear_alarm)
            report_mismatch("clear_alarm", int'(res_i.clear_alarm), int'(want.clear_alarm));
        end
      end
      if (smp_i.valid && smp_i.ready) begin
        smp.encoder_count = smp_i.encoder_count;
        smp.main_pressed  = smp_i.main_pressed;
        smp.aux_pressed   = smp_i.aux_pressed;
        smp.now_ms        = smp_i.now_ms;
        step_event_q.push_back(qualify_sample(smp));
      end
      pending_o = step_event_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned PhaseItems  = 240;
  localparam logic [ebiq_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        no_idle;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned fail_count;
  int unsigned pending;

  // shadow of the programmed values, only used to shape stimulus
  int unsigned thr_set;
  int unsigned long_set;
  int unsigned deb_set;

  ebiq_in_if  in_ch ();
  ebiq_out_if out_ch ();
  ebiq_cfg_if cfg_ch ();

  encoder_button_input_qualifier_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  qualifier_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .smp_i        (in_ch),
    .res_i        (out_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left == 0) stall_left = pick_gap();
    if (stall_left != 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // valid stays high across back-to-back beats when no gap is picked
  task automatic send_sample(logic [ebiq_pkg::CountW-1:0] cnt, logic main_p, logic aux_p,
                             logic [ebiq_pkg::TimeW-1:0] now);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.encoder_count = cnt;
    in_ch.main_pressed  = main_p;
    in_ch.aux_pressed   = aux_p;
    in_ch.now_ms        = now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(logic [ebiq_pkg::CfgIdxW-1:0] idx,
                           logic [ebiq_pkg::CfgDataW-1:0] data);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      cfg_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // stop sampling and wait until every result is back
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(logic [ebiq_pkg::CfgDataW-1:0] thr,
                           logic [ebiq_pkg::CfgDataW-1:0] lng,
                           logic [ebiq_pkg::CfgDataW-1:0] deb);
    write_reg(ebiq_pkg::REG_STEP_THRESHOLD, thr);
    write_reg(RegUnused, ebiq_pkg::CfgDataW'($urandom()));
    write_reg(ebiq_pkg::REG_HOLD_LIMIT, lng);
    write_reg(ebiq_pkg::REG_DEBOUNCE_MS, deb);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    thr_set  = 32'(thr[ebiq_pkg::ThreshW-1:0]);
    long_set = 32'(lng);
    deb_set  = 32'(deb);
  endtask

  initial begin
    logic [ebiq_pkg::CountW-1:0] cnt;
    logic [ebiq_pkg::TimeW-1:0]  now;
    logic                        main_p;
    logic                        aux_p;
    int                          d;
    int unsigned                 span;
    int unsigned                 thr_near;

    rst_n               = 1'b0;
    no_idle             = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.encoder_count = '0;
    in_ch.main_pressed  = 1'b0;
    in_ch.aux_pressed   = 1'b0;
    in_ch.now_ms        = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    thr_set             = 32'(ebiq_pkg::StepThreshRst);
    long_set            = 32'(ebiq_pkg::LongPressRst);
    deb_set             = 32'(ebiq_pkg::DebounceRst);
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // reset defaults: aux locked out right after reset, then steps both ways
    send_sample(16'd32000, 1'b0, 1'b1, 32'd50);
    send_sample(16'd32004, 1'b0, 1'b1, 32'd101);
    send_sample(16'd32000, 1'b0, 1'b1, 32'd150);
    // press starts at the top of the time range, long press across the wrap
    send_sample(16'hFFFF, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_sample(16'hFFFF, 1'b1, 1'b0, 32'd599);
    // counter change of -32768 and aux taking over the long press
    send_sample(16'h7FFF, 1'b1, 1'b1, 32'd600);
    send_sample(16'h7FFF, 1'b0, 1'b0, 32'd2100);
    // held exactly the debounce time, then one more ms
    send_sample(16'h7FFF, 1'b1, 1'b0, 32'd3000);
    send_sample(16'h7FFF, 1'b0, 1'b0, 32'd3100);
    send_sample(16'h7FFF, 1'b1, 1'b0, 32'd4000);
    send_sample(16'h8003, 1'b0, 1'b0, 32'd4101);
    // short press replaced by aux
    send_sample(16'h0000, 1'b1, 1'b0, 32'd5000);
    send_sample(16'h0000, 1'b0, 1'b1, 32'd5101);
    drain();

    // zero threshold written through the masked bit, zero times
    configure(16'h8000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 1'b1, 1'b1, 32'd5101);
    send_sample(16'h0000, 1'b1, 1'b1, 32'd5102);
    send_sample(16'h0001, 1'b0, 1'b0, 32'd5102);
    send_sample(16'h0001, 1'b1, 1'b0, 32'd5200);
    send_sample(16'h0001, 1'b0, 1'b0, 32'd5200);
    drain();

    // largest settings
    configure(16'h7FFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'h1000, 1'b1, 1'b0, 32'd100000);
    send_sample(16'h8FFF, 1'b1, 1'b0, 32'd165535);
    send_sample(16'h0FFF, 1'b1, 1'b0, 32'd165536);
    send_sample(16'h0FFF, 1'b0, 1'b1, 32'd200000);
    send_sample(16'h0FFF, 1'b0, 1'b1, 32'd265535);
    drain();

    cnt    = 16'h0FFF;
    now    = 32'd300000;
    main_p = 1'b0;
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        1: configure(16'd1, 16'd0, 16'd0);
        4: configure(16'h7FFF, 16'hFFFF, 16'hFFFF);
        6: configure(16'($urandom_range(0, 3)), 16'($urandom_range(0, 20)),
                     16'($urandom_range(0, 20)));
        default: configure(16'($urandom_range(1, 24)), 16'($urandom_range(50, 900)),
                           16'($urandom_range(10, 250)));
      endcase
      no_idle  = (phase == 3);
      span     = long_set / 8 + deb_set / 8 + 4;
      thr_near = (thr_set > 64) ? 64 : thr_set;
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        case ($urandom_range(0, 19))
          0: now = $urandom();
          1, 2: now += $urandom_range(0, long_set + deb_set + 2);
          default: now += $urandom_range(0, span);
        endcase
        case ($urandom_range(0, 19))
          0: cnt = ebiq_pkg::CountW'($urandom());
          1: cnt += 16'h8000;
          2: cnt += ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8001;
          default: begin
            d   = int'($urandom_range(0, 4 * thr_near + 4)) - int'(2 * thr_near + 2);
            cnt += d[ebiq_pkg::CountW-1:0];
          end
        endcase
        if ($urandom_range(0, 5) == 0) main_p = !main_p;
        aux_p = ($urandom_range(0, 7) == 0);
        send_sample(cnt, main_p, aux_p, now);
      end
      drain();
    end
    no_idle = 1'b0;

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/ebiq_pkg.sv
src/ebiq_if.sv
src/ebiq_core.sv
src/encoder_button_input_qualifier_top.sv
tb/ebiq_checker.sv
tb/testbench.sv
